FILE: rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared widths, lane count and opcode encoding for the four-lane vector ALU.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int unsigned LANES    = 4;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OP_W     = 5;
    localparam int unsigned SHAMT_W  = 5;
    localparam int unsigned PROD_W   = 2 * WORD_W;
    localparam int unsigned IN_W     = (2 * LANES + 1) * WORD_W;
    localparam int unsigned OUT_W    = 2 * LANES * WORD_W;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_MOVE = 5'd0,
        OP_WSHL = 5'd1,
        OP_WSHR = 5'd2,
        OP_SLL  = 5'd3,
        OP_SRL  = 5'd4,
        OP_SLA  = 5'd5,
        OP_SRA  = 5'd6,
        OP_ADD  = 5'd7,
        OP_ADDS = 5'd8,
        OP_SUB  = 5'd9,
        OP_SUBS = 5'd10,
        OP_MUL  = 5'd11,
        OP_MULS = 5'd12,
        OP_AND  = 5'd13,
        OP_XOR  = 5'd14,
        OP_OR   = 5'd15,
        OP_NOR  = 5'd16
    } op_t;

endpackage

FILE: rtl/simd_four_lane_alu.sv
// ----------------------------------------------------------------------------
// simd_four_lane_alu
// Four-lane 32-bit vector ALU: shifts, add/sub, signed multiply, logic ops.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one request per handshake: the opcode in s_tuser
//   and the vectors a, b plus the scalar in s_tdata. Master channel (m_*)
//   returns one result per request: four lo lanes and four hi lanes.
//   The request is held in an input register; the lane logic (one 32x32
//   signed multiplier per lane is the longest path) feeds the result register.
//   Throughput: one request per cycle, sustained while m_tready stays high.
//   Stall: when the result register holds an untaken result, the input stage
//   stops advancing; once the input stage is also full, s_tready drops. No
//   request is lost or repeated. s_tready follows m_tready combinationally.
//   Reset: rst_n clears both valid flags; the payload registers are not reset.
//   hi lanes are zero for every opcode but mul and muls; undefined opcodes
//   give an all-zero result.
// ----------------------------------------------------------------------------
module simd_four_lane_alu (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // a_lane0, a_lane1, a_lane2, a_lane3, b_lane0 .. b_lane3, scalar_value
    input  logic [sfla_pkg::IN_W-1:0]  s_tdata,
    // op
    input  logic [sfla_pkg::OP_W-1:0]  s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // lo_lane0 .. lo_lane3, hi_lane0 .. hi_lane3
    output logic [sfla_pkg::OUT_W-1:0] m_tdata
);
    import sfla_pkg::*;

    // Input stage
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    op_t                  op_reg;
    word_t                a_reg [LANES];
    word_t                b_reg [LANES];
    word_t                sc_reg;

    // Result stage
    logic                 out_valid_reg;
    logic                 out_valid_next;
    word_t                lo_reg [LANES];
    word_t                hi_reg [LANES];

    // Lane logic
    word_t                lo_next [LANES];
    word_t                hi_next [LANES];
    logic signed [PROD_W-1:0] prod [LANES];
    logic [SHAMT_W-1:0]   shamt;
    logic                 s1_advance;
    logic                 in_take;

    // Advance the input stage into the result register when it is free or
    // being emptied this cycle.
    assign s1_advance = !out_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_take    = s_tvalid && s_tready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request; the payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg <= op_t'(s_tuser);
            for (int i = 0; i < LANES; i++)
            begin
                a_reg[i] <= s_tdata[i*WORD_W +: WORD_W];
                b_reg[i] <= s_tdata[(LANES+i)*WORD_W +: WORD_W];
            end
            sc_reg <= s_tdata[2*LANES*WORD_W +: WORD_W];
        end
    end

    assign shamt = sc_reg[SHAMT_W-1:0];

    // One signed multiplier per lane; muls broadcasts the scalar.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (op_reg == OP_MULS)
                prod[i] = $signed(a_reg[i]) * $signed(sc_reg);
            else
                prod[i] = $signed(a_reg[i]) * $signed(b_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lo_next[i] = '0;
            hi_next[i] = '0;
        end
        case (op_reg)
            OP_MOVE:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i];
            end
            OP_WSHL:
            begin
                // Lane 0 takes the scalar, the rest move up one lane.
                lo_next[0] = sc_reg;
                for (int i = 1; i < LANES; i++)
                    lo_next[i] = a_reg[i-1];
            end
            OP_WSHR:
            begin
                // Top lane takes the scalar, the rest move down one lane.
                for (int i = 0; i < LANES - 1; i++)
                    lo_next[i] = a_reg[i+1];
                lo_next[LANES-1] = sc_reg;
            end
            OP_SLL, OP_SLA:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i] << shamt;
            end
            OP_SRL:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i] >> shamt;
            end
            OP_SRA:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = word_t'($signed(a_reg[i]) >>> shamt);
            end
            OP_ADD:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i] + b_reg[i];
            end
            OP_ADDS:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i] + sc_reg;
            end
            OP_SUB:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i] - b_reg[i];
            end
            OP_SUBS:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i] - sc_reg;
            end
            OP_MUL, OP_MULS:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    lo_next[i] = prod[i][WORD_W-1:0];
                    hi_next[i] = prod[i][PROD_W-1:WORD_W];
                end
            end
            OP_AND:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i] & b_reg[i];
            end
            OP_XOR:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i] ^ b_reg[i];
            end
            OP_OR:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = a_reg[i] | b_reg[i];
            end
            OP_NOR:
            begin
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = ~(a_reg[i] | b_reg[i]);
            end
            default:
            begin
                // Undefined opcode: all-zero result.
                for (int i = 0; i < LANES; i++)
                    lo_next[i] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                lo_reg[i] <= lo_next[i];
                hi_reg[i] <= hi_next[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            m_tdata[i*WORD_W +: WORD_W]         = lo_reg[i];
            m_tdata[(LANES+i)*WORD_W +: WORD_W] = hi_reg[i];
        end
    end

`ifndef SYNTH
    // A full input stage behind a stalled result must back-pressure.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are stalled");

    // A request leaving the input stage shows up as a result next cycle.
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance) |=> m_tvalid)
        else $error("result missing after input stage advanced");

    // hi lanes stay zero for everything but multiplies.
    a_hi_zero_non_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance && op_reg != OP_MUL && op_reg != OP_MULS)
        |=> (m_tdata[OUT_W-1:LANES*WORD_W] == '0))
        else $error("hi lanes nonzero for a non-multiply opcode");

    // Move passes vector a straight through.
    a_move_passes_a: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance && op_reg == OP_MOVE)
        |=> (m_tdata[WORD_W-1:0] == $past(a_reg[0])
             && m_tdata[LANES*WORD_W-1:(LANES-1)*WORD_W] == $past(a_reg[LANES-1])))
        else $error("move result differs from source vector");
`endif

endmodule
